[src/macfar_pkg.sv]
`default_nettype none

package macfar_pkg;

  // sample history
  localparam int MAX_WINDOW = 1024;
  localparam int HIST_AW    = $clog2(MAX_WINDOW);
  localparam int FILL_W     = HIST_AW + 1;

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 11;
  localparam int GAIN_W     = 16;
  localparam int STAT_W     = 32;

  // datapath widths
  localparam int SUM_W      = SAMPLE_W + 11;
  localparam int SPREAD_W   = SAMPLE_W + 24;
  localparam int DEV_W      = SAMPLE_W + 8;
  localparam int MEAN_W     = SAMPLE_W + 9;
  localparam int REF_W      = SAMPLE_W + 10;
  localparam int DIVQ_W     = SAMPLE_W + 24;
  localparam int DIVD_W     = REF_W - 1;
  localparam int TOT_W      = DIVQ_W + 2;

  // step counts of the serial units
  localparam int DIV1_STEPS = SUM_W + 8;
  localparam int DIV2_STEPS = DIVQ_W;
  localparam int MUL_STEPS  = GAIN_W;
  localparam int STEP_W     = $clog2(DIVQ_W + 1);
  localparam int SC_W       = $clog2(MUL_STEPS + 1);

  localparam logic [DEV_W-1:0]  MEAN_LIM = DEV_W'(1) << (SAMPLE_W + 7);
  localparam logic [STAT_W-1:0] STAT_MAX = {1'b0, {(STAT_W-1){1'b1}}};
  localparam logic [STAT_W-1:0] STAT_MIN = {1'b1, {(STAT_W-1){1'b0}}};

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IIR_GAIN         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OFFSET = 2'd2;

  localparam logic [LEN_W-1:0]         WINDOW_RST = 11'd64;
  localparam logic [GAIN_W-1:0]        GAIN_RST   = 16'd7;
  localparam logic signed [STAT_W-1:0] OFFSET_RST = '0;

endpackage

`default_nettype wire

[src/macfar_if.sv]
`default_nettype none

interface macfar_in_if import macfar_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface macfar_out_if import macfar_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [STAT_W-1:0] statistic;
  logic                     reference_zero;

  modport source (output valid, output statistic, output reference_zero, input ready);
  modport sink   (input valid, input statistic, input reference_zero, output ready);
endinterface

`default_nettype wire

[src/macfar_ram.sv]
`default_nettype none

module macfar_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/moving_average_cfar_statistic.sv]
`default_nettype none

// Moving-average CFAR statistic. Each sample transfer updates a running sum over
// the last window_length samples (held in a 1024-entry history RAM; slots never
// written count as zero), forms the window mean and the absolute
// deviation, runs the spread IIR and outputs sample / (spread + mean) plus
// threshold_offset in saturated Q16.16. One item is worked on at a time: the
// next sample is taken once the result register holds the last result, and the
// statistic division is skipped when the reference level is zero. The work is
// done by the shared radix-2 divider, one quotient bit per cycle (35 steps for
// the mean, 40 for the statistic), and the 16-step bit-serial gain multiplier.
// The result register lets the next sample in while a result waits. Configuration
// must be written by the user only while the block is idle, which is not enforced.
module moving_average_cfar_statistic import macfar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  macfar_in_if.sink             in_ch,
  macfar_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_READ   = 10'b00_0000_0010,
    S_DIV1   = 10'b00_0000_0100,
    S_MEAN   = 10'b00_0000_1000,
    S_DEV    = 10'b00_0001_0000,
    S_MUL    = 10'b00_0010_0000,
    S_SPREAD = 10'b00_0100_0000,
    S_REF    = 10'b00_1000_0000,
    S_DIV2   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [LEN_W-1:0]         window_length_r;
  logic [GAIN_W-1:0]        iir_gain_r;
  logic signed [STAT_W-1:0] threshold_offset_r;

  // model state
  logic [HIST_AW-1:0]       ptr_r;
  logic [FILL_W-1:0]        fill_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [SPREAD_W-1:0]      spread_r;

  // working registers
  logic signed [SAMPLE_W-1:0] s_r;
  logic                       old_valid_r;
  logic [STEP_W-1:0]          step_cnt_r;
  logic [SC_W-1:0]            sc_cnt_r;
  logic [SPREAD_W-1:0]        sc_acc_r;
  logic [GAIN_W-1:0]          sc_k_r;
  logic [DIVD_W-1:0]          div_rem_r;
  logic [DIVQ_W-1:0]          div_q_r;
  logic [DIVD_W-1:0]          div_d_r;
  logic                       neg_r;
  logic signed [MEAN_W-1:0]   mean_r;
  logic [DEV_W-1:0]           dev_r;
  logic [SPREAD_W-1:0]        p_r;
  logic [GAIN_W-1:0]          gb_r;
  logic                       zero_r;
  logic                       out_valid_r;
  logic [STAT_W-1:0]          out_stat_r;
  logic                       out_zero_r;

  // combinational
  logic                       in_xfer;
  logic                       out_free;
  logic [LEN_W-1:0]           len_eff;
  logic [HIST_AW-1:0]         old_idx;
  logic [SAMPLE_W-1:0]        hist_rdata;
  logic signed [SAMPLE_W-1:0] old_smp;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic [SUM_W-1:0]           sum_mag;
  logic [DIVD_W:0]            rem_sh;
  logic [DIVD_W:0]            rem_diff;
  logic                       div_ge;
  logic [DIVD_W-1:0]          div_rem_nxt;
  logic [DIVQ_W-1:0]          div_q_nxt;
  logic [DEV_W-1:0]           mean_mag;
  logic signed [MEAN_W-1:0]   mean_val;
  logic signed [DEV_W-1:0]    s_q8;
  logic signed [REF_W-1:0]    d_pos;
  logic signed [REF_W-1:0]    d_neg;
  logic [REF_W-1:0]           d_abs;
  logic [DEV_W-1:0]           dev_sat;
  logic [SPREAD_W-1:0]        p_nxt;
  logic [SPREAD_W:0]          sc_sum;
  logic [SPREAD_W-1:0]        scale_term;
  logic [SPREAD_W-1:0]        spread_nxt;
  logic signed [REF_W-1:0]    ref_val;
  logic [REF_W-1:0]           ref_mag;
  logic [SAMPLE_W-1:0]        s_mag;
  logic [TOT_W-1:0]           q_ext;
  logic [TOT_W-1:0]           off_ext;
  logic [TOT_W-1:0]           tot;
  logic                       tot_ovf;
  logic [STAT_W-1:0]          stat_sat;
  logic [STAT_W-1:0]          stat_val;

  assign in_xfer        = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_free       = !out_valid_r || out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.statistic      = out_stat_r;
  assign out_ch.reference_zero = out_zero_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r    <= WINDOW_RST;
      iir_gain_r         <= GAIN_RST;
      threshold_offset_r <= OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH:    window_length_r    <= cfg_data[LEN_W-1:0];
        CFG_IIR_GAIN:         iir_gain_r         <= cfg_data[GAIN_W-1:0];
        CFG_THRESHOLD_OFFSET: threshold_offset_r <= cfg_data[STAT_W-1:0];
        default: ;
      endcase
    end
  end

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (window_length_r > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = window_length_r;
    end
  end

  assign old_idx = ptr_r - len_eff[HIST_AW-1:0];

  macfar_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (ptr_r),
    .wdata (in_ch.sample),
    .raddr (old_idx),
    .rdata (hist_rdata)
  );

  // running sum and mean dividend
  assign old_smp = old_valid_r ? hist_rdata : '0;
  assign sum_nxt = sum_r + SUM_W'(s_r) - SUM_W'(old_smp);
  assign sum_mag = sum_nxt[SUM_W-1] ? (~sum_nxt + 1'b1) : sum_nxt;

  // restoring divider step, one quotient bit per cycle
  assign rem_sh      = {div_rem_r, div_q_r[DIVQ_W-1]};
  assign rem_diff    = rem_sh - {1'b0, div_d_r};
  assign div_ge      = (rem_sh >= {1'b0, div_d_r});
  assign div_rem_nxt = div_ge ? rem_diff[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
  assign div_q_nxt   = {div_q_r[DIVQ_W-2:0], div_ge};

  // mean, truncated toward zero and clamped
  assign mean_mag = (div_q_r > DIVQ_W'(MEAN_LIM)) ? MEAN_LIM : div_q_r[DEV_W-1:0];
  assign mean_val = neg_r ? (~{1'b0, mean_mag} + 1'b1) : {1'b0, mean_mag};

  // absolute deviation with both differences side by side
  assign s_q8    = {s_r, 8'b0};
  assign d_pos   = REF_W'(s_q8) - REF_W'(mean_r);
  assign d_neg   = REF_W'(mean_r) - REF_W'(s_q8);
  assign d_abs   = d_pos[REF_W-1] ? d_neg : d_pos;
  assign dev_sat = d_abs[DEV_W] ? '1 : d_abs[DEV_W-1:0];

  // dev * gain, msb first
  assign p_nxt = {p_r[SPREAD_W-2:0], 1'b0} + (gb_r[GAIN_W-1] ? SPREAD_W'(dev_r) : '0);

  // spread * (65536 - gain) / 65536, lsb first with the low bits dropped each step
  assign sc_sum     = {1'b0, sc_acc_r} + (sc_k_r[0] ? {1'b0, spread_r} : '0);
  assign scale_term = (iir_gain_r == '0) ? spread_r : sc_acc_r;
  assign spread_nxt = scale_term + p_r;

  // reference level and statistic dividend
  assign ref_val = signed'({2'b00, spread_r[SPREAD_W-1:GAIN_W]}) + REF_W'(mean_r);
  assign ref_mag = ref_val[REF_W-1] ? (~ref_val + 1'b1) : ref_val;
  assign s_mag   = s_r[SAMPLE_W-1] ? (~s_r + 1'b1) : s_r;

  // signed quotient plus offset in one adder, then saturate
  assign q_ext    = {2'b00, div_q_r};
  assign off_ext  = TOT_W'(threshold_offset_r);
  assign tot      = off_ext + (neg_r ? ~q_ext : q_ext) + TOT_W'(neg_r);
  assign tot_ovf  = (tot[TOT_W-1:STAT_W-1] != '0) && (tot[TOT_W-1:STAT_W-1] != '1);
  assign stat_sat = tot_ovf ? (tot[TOT_W-1] ? STAT_MIN : STAT_MAX) : tot[STAT_W-1:0];
  assign stat_val = zero_r ? (s_r[SAMPLE_W-1] ? STAT_MIN : STAT_MAX) : stat_sat;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_READ;
      S_READ:   state_nxt = S_DIV1;
      S_DIV1:   if (step_cnt_r == STEP_W'(1)) state_nxt = S_MEAN;
      S_MEAN:   state_nxt = S_DEV;
      S_DEV:    state_nxt = S_MUL;
      S_MUL:    if (step_cnt_r == STEP_W'(1)) state_nxt = S_SPREAD;
      S_SPREAD: state_nxt = S_REF;
      S_REF:    state_nxt = (ref_val == '0) ? S_DONE : S_DIV2;
      S_DIV2:   if (step_cnt_r == STEP_W'(1)) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control and model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      spread_r    <= '0;
      step_cnt_r  <= '0;
      sc_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (in_xfer) begin
        ptr_r    <= ptr_r + 1'b1;
        fill_r   <= (fill_r == FILL_W'(MAX_WINDOW)) ? fill_r : fill_r + 1'b1;
        sc_cnt_r <= SC_W'(MUL_STEPS);
      end else if (sc_cnt_r != '0) begin
        sc_cnt_r <= sc_cnt_r - 1'b1;
      end

      unique case (state_r) inside
        S_READ: begin
          sum_r      <= sum_nxt;
          step_cnt_r <= STEP_W'(DIV1_STEPS);
        end
        S_DEV:    step_cnt_r <= STEP_W'(MUL_STEPS);
        S_REF:    step_cnt_r <= STEP_W'(DIV2_STEPS);
        S_DIV1, S_MUL, S_DIV2: step_cnt_r <= step_cnt_r - 1'b1;
        S_SPREAD: spread_r <= spread_nxt;
        default: ;
      endcase

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_r         <= in_ch.sample;
      old_valid_r <= (fill_r > {1'b0, old_idx});
      sc_acc_r    <= '0;
      sc_k_r      <= ~iir_gain_r + 1'b1;
    end else if (sc_cnt_r != '0) begin
      sc_acc_r <= sc_sum[SPREAD_W:1];
      sc_k_r   <= sc_k_r >> 1;
    end

    unique case (state_r) inside
      S_READ: begin
        div_rem_r <= '0;
        div_q_r   <= {sum_mag, {(DIVQ_W-SUM_W){1'b0}}};
        div_d_r   <= DIVD_W'(len_eff);
        neg_r     <= sum_nxt[SUM_W-1];
      end
      S_DIV1, S_DIV2: begin
        div_rem_r <= div_rem_nxt;
        div_q_r   <= div_q_nxt;
      end
      S_MEAN: mean_r <= mean_val;
      S_DEV: begin
        dev_r <= dev_sat;
        p_r   <= '0;
        gb_r  <= iir_gain_r;
      end
      S_MUL: begin
        p_r  <= p_nxt;
        gb_r <= gb_r << 1;
      end
      S_REF: begin
        zero_r    <= (ref_val == '0);
        div_rem_r <= '0;
        div_q_r   <= {s_mag, {(DIVQ_W-SAMPLE_W){1'b0}}};
        div_d_r   <= ref_mag[DIVD_W-1:0];
        neg_r     <= s_r[SAMPLE_W-1] ^ ref_val[REF_W-1];
      end
      S_DONE: begin
        if (out_free) begin
          out_stat_r <= stat_val;
          out_zero_r <= zero_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // until the history wraps, the write slot tracks the fill count
  a_fill_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FILL_W'(MAX_WINDOW)) |-> (ptr_r == fill_r[HIST_AW-1:0]))
    else $error("history pointer out of step with fill count");

  // the gain scaling of the old spread is done before the spread is updated
  a_scale_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPREAD) |-> (sc_cnt_r == '0))
    else $error("spread scaling still running at spread update");

  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.reference_zero) |->
      (out_ch.statistic == STAT_MAX || out_ch.statistic == STAT_MIN))
    else $error("zero reference without saturated statistic");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown outside of the done state");
`endif

endmodule

`default_nettype wire

[verif/tb_moving_average_cfar_statistic.sv]
`timescale 1ns / 100ps

module tb_moving_average_cfar_statistic;
  import macfar_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int ITEMS_PER_PHASE = 200;
  localparam int RAND_PHASES     = 8;
  localparam int HOLD_AFTER      = 300;
  localparam int HOLD_CYCLES     = 2500;
  localparam int DRAIN_CYCLES    = 150;
  localparam int CYCLE_LIMIT     = 1000000;

  localparam longint     MEAN_BOUND = longint'(1) << (SAMPLE_W + 7);
  localparam logic [63:0] DEV_CAP   = (64'd1 << DEV_W) - 64'd1;
  localparam longint     DIV_SCALE  = longint'(1) << 24;
  localparam longint     STAT_HI    = (longint'(1) << (STAT_W - 1)) - 1;
  localparam longint     STAT_LO    = -(longint'(1) << (STAT_W - 1));

  typedef enum int {SEG_NOISE, SEG_QUIET, SEG_FULL, SEG_EXTREME, SEG_BURST} seg_kind_t;

  typedef struct packed {
    logic signed [STAT_W-1:0] statistic;
    logic                     ref_zero;
  } cfar_result_t;

  class cfar_scoreboard;
    logic signed [SAMPLE_W-1:0] history [MAX_WINDOW];
    logic [HIST_AW-1:0]         wr_ptr;
    logic [SUM_W-1:0]           run_sum;
    logic [SPREAD_W-1:0]        spread;
    logic [LEN_W-1:0]           win_len;
    logic [GAIN_W-1:0]          gain;
    logic signed [STAT_W-1:0]   offset;
    cfar_result_t               expected_q [$];
    int                         errors;

    function new();
      foreach (history[i]) history[i] = '0;
      wr_ptr  = '0;
      run_sum = '0;
      spread  = '0;
      win_len = WINDOW_RST;
      gain    = GAIN_RST;
      offset  = OFFSET_RST;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WINDOW_LENGTH:    win_len = data[LEN_W-1:0];
        CFG_IIR_GAIN:         gain    = data[GAIN_W-1:0];
        CFG_THRESHOLD_OFFSET: offset  = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the detector state by one sample and queue the statistic it yields
    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      longint             eff_len, old_val, sum_val, mean, dev, refl, quo;
      logic [63:0]        udev, keep, sp;
      logic [HIST_AW-1:0] old_idx;
      cfar_result_t       r;
      eff_len = (win_len == 0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
      // a window of MAX_WINDOW wraps onto the slot about to be overwritten
      old_idx = wr_ptr - HIST_AW'(eff_len);
      old_val = history[old_idx];
      history[wr_ptr] = s;
      wr_ptr = wr_ptr + 1'b1;
      run_sum = run_sum + SUM_W'(longint'(s) - old_val);
      sum_val = $signed(run_sum);
      mean = (sum_val * 256) / eff_len;
      if (mean > MEAN_BOUND) mean = MEAN_BOUND;
      if (mean < -MEAN_BOUND) mean = -MEAN_BOUND;
      dev  = longint'(s) * 256 - mean;
      udev = (dev < 0) ? -dev : dev;
      if (udev > DEV_CAP) udev = DEV_CAP;
      keep = 64'd65536 - 64'(gain);
      sp   = 64'(spread);
      sp   = (sp >> 16) * keep + (((sp & 64'hFFFF) * keep) >> 16) + udev * 64'(gain);
      spread = sp[SPREAD_W-1:0];
      refl = longint'(spread >> 16) + mean;
      if (refl == 0) begin
        r.ref_zero  = 1'b1;
        r.statistic = (s < 0) ? STAT_MIN : STAT_MAX;
      end else begin
        quo = (longint'(s) * DIV_SCALE) / refl + longint'(offset);
        if (quo > STAT_HI) quo = STAT_HI;
        if (quo < STAT_LO) quo = STAT_LO;
        r.ref_zero  = 1'b0;
        r.statistic = STAT_W'(quo);
      end
      expected_q.push_back(r);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_result(logic signed [STAT_W-1:0] stat, logic zero);
      cfar_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("statistic %h arrived with nothing outstanding", stat));
        return;
      end
      want = expected_q.pop_front();
      if (stat !== want.statistic)
        report($sformatf("statistic %h, expected %h", stat, want.statistic));
      if (zero !== want.ref_zero)
        report($sformatf("reference_zero %b, expected %b", zero, want.ref_zero));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    gaps_on = 1'b1;

  macfar_in_if  in_ch ();
  macfar_out_if out_ch ();

  cfar_scoreboard sb = new();

  moving_average_cfar_statistic dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.statistic, out_ch.reference_zero);
    end
  end

  // result sink: random stalls, plus one long hold-off to back the block up
  int rx_seen = 0;
  int rx_hold = 0;
  bit rx_held = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) rx_seen++;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (!rx_held && rx_seen >= HOLD_AFTER) begin
        rx_held = 1'b1;
        rx_hold = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 31);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("moving_average_cfar_statistic regression: fail");
    $finish;
  end

  // valid is left high after a transfer; the next call or the caller decides
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] len, gain, offs);
    write_cfg(CFG_WINDOW_LENGTH, len);
    write_cfg(CFG_IIR_GAIN, gain);
    write_cfg(CFG_THRESHOLD_OFFSET, offs);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_len();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 1;
      2:       return MAX_WINDOW;
      3:       return $urandom_range(MAX_WINDOW + 1, 2047);
      4, 5:    return $urandom_range(2, 16);
      default: return $urandom_range(1, MAX_WINDOW);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(1, 64);
      3:       return 7;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(4))
      0:       return 0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom;
      default: return CFG_DATA_W'(($urandom_range(0, 8) - 4) * 65536);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(seg_kind_t kind, int floor_lvl);
    case (kind)
      SEG_NOISE:   return SAMPLE_W'(floor_lvl + $urandom_range(0, 64) - 32);
      SEG_QUIET:   return '0;
      SEG_FULL:    return SAMPLE_W'($urandom);
      SEG_EXTREME: begin
        case ($urandom_range(3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: begin
        if ($urandom_range(1)) return SAMPLE_W'($urandom_range(8000, 32767));
        return SAMPLE_W'(-$urandom_range(8000, 32768));
      end
    endcase
  endfunction

  initial begin
    int        n, seg_len, k, floor_lvl;
    seg_kind_t kind;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: an empty history gives a zero reference
    send_sample(0);
    settle();

    // no spread, long window: tiny sums truncate to a zero mean
    configure(MAX_WINDOW, 0, 0);
    send_sample(1);
    send_sample(-1);
    send_sample(-1);
    send_sample(1);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    settle();

    // window length zero acts as one, full gain, offset at the top
    configure(0, 65535, 32'h7FFF_FFFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(100);
    send_sample(-100);
    settle();

    // oversize window clamps to the history depth, offset at the bottom
    configure(2047, 1, 32'h8000_0000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(0);
    send_sample(12345);
    settle();

    // a write to an unused index must leave every register alone
    write_cfg(CFG_SPARE, $urandom);
    configure(MAX_WINDOW + 1, 32768, 32'h0001_0000);
    send_sample(-5);
    send_sample(7);
    send_sample(0);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      gaps_on = (ph != 2);
      configure(pick_len(), pick_gain(), pick_offset());
      floor_lvl = $urandom_range(0, 400) - 200;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        kind    = seg_kind_t'($urandom_range(SEG_NOISE, SEG_BURST));
        seg_len = $urandom_range(8, 40);
        for (k = 0; k < seg_len && n < ITEMS_PER_PHASE; k++) begin
          send_sample(pick_sample(kind, floor_lvl));
          n++;
        end
      end
      settle();
    end
    gaps_on = 1'b1;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected statistics never arrived");
    if (sb.errors == 0) begin
      $display("moving_average_cfar_statistic regression: pass");
    end else begin
      $display("moving_average_cfar_statistic regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/macfar_pkg.sv
src/macfar_if.sv
src/macfar_ram.sv
src/moving_average_cfar_statistic.sv
verif/tb_moving_average_cfar_statistic.sv
